// ----- design/cosine_vote_matcher_assert.svh -----
// Assertion helpers used by the checker file of this block.
// Each macro samples on the rising edge of clk and is disabled during reset.
`ifndef COSINE_VOTE_MATCHER_ASSERT_SVH
`define COSINE_VOTE_MATCHER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CVM_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define CVM_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- design/cvm_pkg.sv -----
package cvm_pkg;

	// Input element format and vector limits.
	localparam int ELEM_W     = 16;
	localparam int MAX_ELEMS  = 256;
	localparam int ELEM_CNT_W = $clog2(MAX_ELEMS + 1);

	// Set limits and counter width of the result fields.
	localparam int MAX_PHOTOS = 64;
	localparam int CNT_W      = 7;

	// Accumulator widths.
	localparam int PROD1_W = 2 * ELEM_W;
	localparam int DOT_W   = 40;
	localparam int SQ_W    = 39;
	localparam int MAG_W   = 39;

	// Configuration widths.
	localparam int THR_W  = 16;
	localparam int FRAC_W = 17;
	localparam int TMAG_W = THR_W + 1;
	localparam int TSQ_W  = 31;
	localparam int RHS_W  = FRAC_W + CNT_W;
	localparam int LHS_SHIFT = 16;

	// Exact compare widths: dot^2 * 2^30 against refsq * probesq * thr^2.
	localparam int P_W    = 2 * MAG_W;
	localparam int RES_W  = 110;
	localparam int SCALE_SHIFT = 30;

	// Digit-serial multiplier.
	localparam int DIGIT_W   = 8;
	localparam int MPL_W     = 40;
	localparam int NDIG_SQ   = (MAG_W + DIGIT_W - 1) / DIGIT_W;
	localparam int NDIG_T    = (TSQ_W + DIGIT_W - 1) / DIGIT_W;
	localparam int DIG_CNT_W = 3;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRACTION  = 2'd1;

	// Register reset values.
	localparam logic signed [THR_W-1:0] THR_RESET  = 16'sd16384;
	localparam logic [FRAC_W-1:0]       FRAC_RESET = 17'd32768;

	// Multiplier operations.
	localparam logic [1:0] OP_DOT   = 2'd0;
	localparam logic [1:0] OP_NORM  = 2'd1;
	localparam logic [1:0] OP_SCALE = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load_vec;
		logic       mul_init;
		logic       mul_step;
		logic       capture;
		logic [1:0] mul_op;
		logic       decide;
		logic       calc_match;
		logic       load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic early;
	} sts_t;

endpackage

// ----- design/cvm_datapath.sv -----
module cvm_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_accept,
	input  logic signed [cvm_pkg::ELEM_W-1:0]   ref_elem,
	input  logic signed [cvm_pkg::ELEM_W-1:0]   probe_elem,
	input  logic                                last_elem,
	input  logic                                cfg_we,
	input  logic [cvm_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [cvm_pkg::FRAC_W-1:0]          cfg_wdata,
	input  cvm_pkg::cmd_t                       cmd,
	output cvm_pkg::sts_t                       sts,
	output logic                                is_match,
	output logic [cvm_pkg::CNT_W-1:0]           positive_votes,
	output logic [cvm_pkg::CNT_W-1:0]           photo_total
);

	logic signed [cvm_pkg::THR_W-1:0]    thr_q;
	logic [cvm_pkg::FRAC_W-1:0]          frac_q;
	logic [cvm_pkg::ELEM_CNT_W-1:0]      elem_cnt_q;
	logic                                valid_s1;
	logic signed [cvm_pkg::PROD1_W-1:0]  dot_p_s1;
	logic signed [cvm_pkg::PROD1_W-1:0]  ref_p_s1;
	logic signed [cvm_pkg::PROD1_W-1:0]  probe_p_s1;
	logic signed [cvm_pkg::DOT_W-1:0]    dot_q;
	logic [cvm_pkg::SQ_W-1:0]            rsq_q;
	logic [cvm_pkg::SQ_W-1:0]            psq_q;
	logic [cvm_pkg::MAG_W-1:0]           mag_q;
	logic [cvm_pkg::SQ_W-1:0]            nrm_a_q;
	logic [cvm_pkg::SQ_W-1:0]            nrm_b_q;
	logic [cvm_pkg::TSQ_W-1:0]           tsq_q;
	logic                                early_q;
	logic                                early_val_q;
	logic                                tneg_q;
	logic [cvm_pkg::RES_W-1:0]           mcand_q;
	logic [cvm_pkg::MPL_W-1:0]           mplier_q;
	logic [cvm_pkg::RES_W-1:0]           prod_q;
	logic [cvm_pkg::P_W-1:0]             p1_q;
	logic [cvm_pkg::P_W-1:0]             p2_q;
	logic [cvm_pkg::CNT_W-1:0]           vote_q;
	logic [cvm_pkg::CNT_W-1:0]           photo_q;
	logic [cvm_pkg::RHS_W-1:0]           rhs_q;
	logic                                match_q;
	logic [cvm_pkg::CNT_W-1:0]           votes_out_q;
	logic [cvm_pkg::CNT_W-1:0]           photos_out_q;

	logic                                dot_neg;
	logic                                dot_zero;
	logic                                thr_neg;
	logic [cvm_pkg::DOT_W-1:0]           dot_abs;
	logic [cvm_pkg::TMAG_W-1:0]          thr_ext;
	logic [cvm_pkg::TMAG_W-1:0]          tmag;
	logic [cvm_pkg::RES_W-1:0]           part;
	logic [cvm_pkg::RES_W-1:0]           left;
	logic                                vote;
	logic [cvm_pkg::RHS_W-1:0]           lhs;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q  <= cvm_pkg::THR_RESET;
			frac_q <= cvm_pkg::FRAC_RESET;
		end else if (cfg_we) begin
			case (cfg_idx)
				cvm_pkg::REG_THRESHOLD: thr_q  <= cfg_wdata[cvm_pkg::THR_W-1:0];
				cvm_pkg::REG_FRACTION:  frac_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Element counter; elements past the vector limit are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			elem_cnt_q <= '0;
			valid_s1   <= 1'b0;
		end else begin
			valid_s1 <= in_accept && (elem_cnt_q < cvm_pkg::ELEM_CNT_W'(cvm_pkg::MAX_ELEMS));
			if (in_accept) begin
				if (last_elem) begin
					elem_cnt_q <= '0;
				end else if (elem_cnt_q < cvm_pkg::ELEM_CNT_W'(cvm_pkg::MAX_ELEMS)) begin
					elem_cnt_q <= elem_cnt_q + 1'b1;
				end
			end
		end
	end

	// Product stage.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			dot_p_s1   <= ref_elem * probe_elem;
			ref_p_s1   <= ref_elem * ref_elem;
			probe_p_s1 <= probe_elem * probe_elem;
		end
	end

	// Accumulate stage; cleared when the vector is handed to the compare.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q <= '0;
			rsq_q <= '0;
			psq_q <= '0;
		end else if (cmd.load_vec) begin
			dot_q <= '0;
			rsq_q <= '0;
			psq_q <= '0;
		end else if (valid_s1) begin
			dot_q <= dot_q + cvm_pkg::DOT_W'(dot_p_s1);
			rsq_q <= rsq_q + cvm_pkg::SQ_W'(ref_p_s1);
			psq_q <= psq_q + cvm_pkg::SQ_W'(probe_p_s1);
		end
	end

	// Sign and zero-norm cases that settle the vote without the exact compare.
	assign dot_neg  = dot_q[cvm_pkg::DOT_W-1];
	assign dot_zero = (dot_q == '0);
	assign thr_neg  = thr_q[cvm_pkg::THR_W-1];
	assign dot_abs  = dot_neg ? cvm_pkg::DOT_W'(-dot_q) : cvm_pkg::DOT_W'(dot_q);
	assign thr_ext  = cvm_pkg::TMAG_W'(thr_q);
	assign tmag     = thr_neg ? cvm_pkg::TMAG_W'(-thr_ext) : thr_ext;

	always_ff @(posedge clk) begin
		if (cmd.load_vec) begin
			mag_q   <= dot_abs[cvm_pkg::MAG_W-1:0];
			nrm_a_q <= rsq_q;
			nrm_b_q <= psq_q;
			tsq_q   <= cvm_pkg::TSQ_W'(tmag) * cvm_pkg::TSQ_W'(tmag);
			tneg_q  <= thr_neg;
			if (rsq_q == '0 || psq_q == '0) begin
				early_q     <= 1'b1;
				early_val_q <= 1'b0;
			end else if (thr_neg && !dot_neg) begin
				early_q     <= 1'b1;
				early_val_q <= 1'b1;
			end else if (!thr_neg && (dot_neg || dot_zero)) begin
				early_q     <= 1'b1;
				early_val_q <= 1'b0;
			end else begin
				early_q     <= 1'b0;
				early_val_q <= 1'b0;
			end
		end
	end

	assign sts.early = early_q;

	// Digit-serial multiplier: one 8-bit digit of the multiplier per step.
	assign part = mcand_q * cvm_pkg::RES_W'(mplier_q[cvm_pkg::DIGIT_W-1:0]);

	always_ff @(posedge clk) begin
		if (cmd.mul_init) begin
			prod_q <= '0;
			case (cmd.mul_op)
				cvm_pkg::OP_DOT: begin
					mcand_q  <= cvm_pkg::RES_W'(mag_q);
					mplier_q <= cvm_pkg::MPL_W'(mag_q);
				end
				cvm_pkg::OP_NORM: begin
					mcand_q  <= cvm_pkg::RES_W'(nrm_a_q);
					mplier_q <= cvm_pkg::MPL_W'(nrm_b_q);
				end
				default: begin
					mcand_q  <= cvm_pkg::RES_W'(p2_q);
					mplier_q <= cvm_pkg::MPL_W'(tsq_q);
				end
			endcase
		end else if (cmd.mul_step) begin
			prod_q   <= prod_q + part;
			mcand_q  <= mcand_q << cvm_pkg::DIGIT_W;
			mplier_q <= mplier_q >> cvm_pkg::DIGIT_W;
		end
	end

	// Keep the partial results that later steps need.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			case (cmd.mul_op)
				cvm_pkg::OP_DOT:  p1_q <= prod_q[cvm_pkg::P_W-1:0];
				cvm_pkg::OP_NORM: p2_q <= prod_q[cvm_pkg::P_W-1:0];
				default: ;
			endcase
		end
	end

	// Vote decision and set counters.
	assign left = cvm_pkg::RES_W'(p1_q) << cvm_pkg::SCALE_SHIFT;
	assign vote = early_q ? early_val_q : (tneg_q ? (left < prod_q) : (left > prod_q));
	assign lhs  = cvm_pkg::RHS_W'(vote_q) << cvm_pkg::LHS_SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vote_q  <= '0;
			photo_q <= '0;
		end else if (cmd.load_out) begin
			vote_q  <= '0;
			photo_q <= '0;
		end else if (cmd.decide && (photo_q < cvm_pkg::CNT_W'(cvm_pkg::MAX_PHOTOS))) begin
			photo_q <= photo_q + 1'b1;
			vote_q  <= vote_q + cvm_pkg::CNT_W'(vote);
		end
	end

	// Match test: votes * 65536 >= fraction * photos.
	always_ff @(posedge clk) begin
		if (cmd.calc_match) begin
			rhs_q <= cvm_pkg::RHS_W'(frac_q) * cvm_pkg::RHS_W'(photo_q);
		end
	end

	// Output payload register.
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			match_q      <= (lhs >= rhs_q);
			votes_out_q  <= vote_q;
			photos_out_q <= photo_q;
		end
	end

	assign is_match       = match_q;
	assign positive_votes = votes_out_q;
	assign photo_total    = photos_out_q;

endmodule

// ----- design/cvm_ctrl.sv -----
module cvm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           last_elem,
	input  logic           last_photo,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	input  cvm_pkg::sts_t  sts,
	output cvm_pkg::cmd_t  cmd
);

	localparam logic [3:0] S_ACC    = 4'd0;
	localparam logic [3:0] S_DRAIN  = 4'd1;
	localparam logic [3:0] S_LOAD   = 4'd2;
	localparam logic [3:0] S_INIT   = 4'd3;
	localparam logic [3:0] S_STEP   = 4'd4;
	localparam logic [3:0] S_CAPT   = 4'd5;
	localparam logic [3:0] S_DECIDE = 4'd6;
	localparam logic [3:0] S_MATCH  = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0]                      state_q;
	logic [1:0]                      op_q;
	logic [cvm_pkg::DIG_CNT_W-1:0]   digit_q;
	logic                            set_end_q;
	logic                            out_valid_q;
	logic                            accept;
	logic                            last_digit;
	logic                            out_room;

	assign in_ready   = (state_q == S_ACC);
	assign accept     = in_valid && in_ready;
	assign out_room   = !out_valid_q || out_ready;
	assign last_digit = (op_q == cvm_pkg::OP_SCALE)
		? (digit_q == cvm_pkg::DIG_CNT_W'(cvm_pkg::NDIG_T - 1))
		: (digit_q == cvm_pkg::DIG_CNT_W'(cvm_pkg::NDIG_SQ - 1));

	// Commands for the current state.
	always_comb begin
		cmd            = '0;
		cmd.mul_op     = op_q;
		cmd.load_vec   = (state_q == S_LOAD);
		cmd.mul_init   = (state_q == S_INIT) && !sts.early;
		cmd.mul_step   = (state_q == S_STEP);
		cmd.capture    = (state_q == S_CAPT);
		cmd.decide     = (state_q == S_DECIDE);
		cmd.calc_match = (state_q == S_MATCH);
		cmd.load_out   = (state_q == S_OUT) && out_room;
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_ACC;
			op_q      <= cvm_pkg::OP_DOT;
			digit_q   <= '0;
			set_end_q <= 1'b0;
		end else begin
			case (state_q)
				S_ACC: begin
					if (accept && last_elem) begin
						set_end_q <= last_photo;
						state_q   <= S_DRAIN;
					end
				end
				S_DRAIN: state_q <= S_LOAD;
				S_LOAD: begin
					op_q    <= cvm_pkg::OP_DOT;
					state_q <= S_INIT;
				end
				S_INIT: begin
					digit_q <= '0;
					state_q <= sts.early ? S_DECIDE : S_STEP;
				end
				S_STEP: begin
					digit_q <= digit_q + 1'b1;
					if (last_digit) begin
						state_q <= S_CAPT;
					end
				end
				S_CAPT: begin
					if (op_q == cvm_pkg::OP_SCALE) begin
						state_q <= S_DECIDE;
					end else begin
						op_q    <= op_q + 1'b1;
						state_q <= S_INIT;
					end
				end
				S_DECIDE: state_q <= set_end_q ? S_MATCH : S_ACC;
				S_MATCH:  state_q <= S_OUT;
				S_OUT: begin
					if (out_room) begin
						state_q <= S_ACC;
					end
				end
				default: state_q <= S_ACC;
			endcase
		end
	end

	// Result valid flag of the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ----- design/cosine_vote_matcher.sv -----
// Cosine-similarity vote matcher. Each input request carries one element of a
// reference vector and the same-index probe element; within a vector one
// request is taken per cycle. After the element marked last, input is held off
// while an 8-bit digit-serial multiplier forms the exact comparison of the
// squared dot product against the product of both squared norms and the
// squared threshold; the multiplier is skipped when the signs or a zero norm
// settle the vote. At the end of a set the match test is formed, and one result
// request is loaded into an output register as soon as the previous one has
// been taken; input is held off meanwhile. Configuration writes are taken in
// any cycle and must be made while the block is idle.
module cosine_vote_matcher (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [2*cvm_pkg::ELEM_W-1:0]       s_axis_tdata,   // ref_elem, probe_elem
	input  logic                               s_axis_tlast,   // last_elem
	input  logic                               s_axis_tuser,   // last_photo
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [15:0]                        m_axis_tdata,   // is_match, positive_votes,
	                                                           // photo_total, zero fill
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [cvm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [cvm_pkg::FRAC_W-1:0]         cfg_data
);

	cvm_pkg::cmd_t                 cmd;
	cvm_pkg::sts_t                 sts;
	logic                          is_match;
	logic [cvm_pkg::CNT_W-1:0]     positive_votes;
	logic [cvm_pkg::CNT_W-1:0]     photo_total;

	assign cfg_ready = 1'b1;

	cvm_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_axis_tvalid),
		.last_elem  (s_axis_tlast),
		.last_photo (s_axis_tuser),
		.in_ready   (s_axis_tready),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.sts        (sts),
		.cmd        (cmd)
	);

	cvm_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_accept      (s_axis_tvalid && s_axis_tready),
		.ref_elem       (s_axis_tdata[cvm_pkg::ELEM_W-1:0]),
		.probe_elem     (s_axis_tdata[2*cvm_pkg::ELEM_W-1:cvm_pkg::ELEM_W]),
		.last_elem      (s_axis_tlast),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_idx        (cfg_index),
		.cfg_wdata      (cfg_data),
		.cmd            (cmd),
		.sts            (sts),
		.is_match       (is_match),
		.positive_votes (positive_votes),
		.photo_total    (photo_total)
	);

	assign m_axis_tdata = {1'b0, photo_total, positive_votes, is_match};

endmodule

// ----- design/cvm_checker.sv -----
`include "cosine_vote_matcher_assert.svh"

module cvm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        s_axis_tlast,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [15:0] m_axis_tdata
);

	// A result waiting on the output holds until it is taken.
	`CVM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
	// A reported set always counts at least one vector.
	`CVM_ASSERT_SAME(a_photos_nonzero, m_axis_tvalid, m_axis_tdata[14:8] != 7'd0)
	// Votes never exceed the vectors counted.
	`CVM_ASSERT_SAME(a_votes_bound, m_axis_tvalid, m_axis_tdata[7:1] <= m_axis_tdata[14:8])
	// After the last element of a vector, input is held off while the vote is formed.
	`CVM_ASSERT_NEXT(a_vec_stall, s_axis_tvalid && s_axis_tready && s_axis_tlast, !s_axis_tready)

endmodule

bind cosine_vote_matcher cvm_checker u_cvm_checker (.*);
